FILE: rtl/core/lcdbuf_pkg.sv
`default_nettype none
package lcdbuf_pkg;

	localparam int MAX_ROWS_DEF = 4;
	localparam int MAX_COLS_DEF = 20;
	localparam int RESULT_CAP   = 20;
	localparam int CNT_W        = $clog2(RESULT_CAP + 1);

	localparam logic [7:0] SPACE_CHAR = 8'h20;

	localparam logic [7:0] OFFSET0_RST = 8'h00;
	localparam logic [7:0] OFFSET1_RST = 8'h40;
	localparam logic [7:0] OFFSET2_RST = 8'h14;
	localparam logic [7:0] OFFSET3_RST = 8'h54;
	localparam logic [2:0] ROWS_RST    = 3'd4;
	localparam logic [4:0] COLS_RST    = 5'd20;

	localparam logic [1:0] MODE_WRITE   = 2'd0;
	localparam logic [1:0] MODE_CLEAR   = 2'd1;
	localparam logic [1:0] MODE_REFRESH = 2'd2;

	localparam logic CMD_CLEAR = 1'b0;
	localparam logic CMD_CHAR  = 1'b1;

	localparam logic [2:0] REG_ROWS    = 3'd0;
	localparam logic [2:0] REG_COLS    = 3'd1;
	localparam logic [2:0] REG_OFFSET0 = 3'd2;
	localparam logic [2:0] REG_OFFSET1 = 3'd3;
	localparam logic [2:0] REG_OFFSET2 = 3'd4;
	localparam logic [2:0] REG_OFFSET3 = 3'd5;

	typedef struct packed {
		logic [1:0] mode;
		logic [2:0] row;
		logic [4:0] col;
		logic [7:0] char_code;
	} in_word_t;

	typedef struct packed {
		logic       command;
		logic [6:0] ddram_address;
		logic [7:0] char_out;
		logic       last;
	} out_word_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WR_CMP,
		ST_SCAN,
		ST_EMIT
	} state_t;

endpackage
`default_nettype wire

FILE: rtl/core/char_lcd_dirty_cell_buffer.sv
`default_nettype none
// Shadow character store for a text display with a dirty mark per cell. Words
// enter one at a time: in_stall is high while a word is being worked on. A cell
// write reads the store, then compares and writes back; a clear drops the store
// on accept and then hands over its single result word. A refresh walks the
// columns of its row one per cycle through the single read port of the store
// while it meets clean cells; each dirty cell adds an emit step that moves its
// result into the output register and waits while out_stall holds it back. The
// walk stops once the last dirty cell, or the RESULT_CAP-th result, is handed
// over; a refresh that finds no dirty cell walks up to cols_in_use (capped at
// the column count), and one for a row not in use or absent, or whose row offset
// has bit 7 set, ends on accept with no result. Results wait in an output
// register.
// After reset the store reads as spaces through per-cell valid bits; there is no
// clearing pass, and a clear item drops all valid bits and marks on accept.
module char_lcd_dirty_cell_buffer #(
	parameter int MAX_ROWS = lcdbuf_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS = lcdbuf_pkg::MAX_COLS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire lcdbuf_pkg::in_word_t  in_data,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output lcdbuf_pkg::out_word_t      out_data,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [4:0]            paddr,
	input  wire logic [31:0]           pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);

	localparam int DEPTH  = MAX_ROWS * MAX_COLS;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int ROW_IW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int COL_IW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int COL_CW = $clog2(MAX_COLS + 1);
	localparam int CNT_W  = lcdbuf_pkg::CNT_W;

	// configuration registers
	logic [2:0] rows_in_use_q;
	logic [4:0] cols_in_use_q;
	logic [7:0] row_offset_q [4];
	logic       cfg_we;

	assign pready = 1'b1;
	assign cfg_we = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_in_use_q   <= lcdbuf_pkg::ROWS_RST;
			cols_in_use_q   <= lcdbuf_pkg::COLS_RST;
			row_offset_q[0] <= lcdbuf_pkg::OFFSET0_RST;
			row_offset_q[1] <= lcdbuf_pkg::OFFSET1_RST;
			row_offset_q[2] <= lcdbuf_pkg::OFFSET2_RST;
			row_offset_q[3] <= lcdbuf_pkg::OFFSET3_RST;
		end else if (cfg_we) begin
			case (paddr[4:2])
				lcdbuf_pkg::REG_ROWS:    rows_in_use_q   <= pwdata[2:0];
				lcdbuf_pkg::REG_COLS:    cols_in_use_q   <= pwdata[4:0];
				lcdbuf_pkg::REG_OFFSET0: row_offset_q[0] <= pwdata[7:0];
				lcdbuf_pkg::REG_OFFSET1: row_offset_q[1] <= pwdata[7:0];
				lcdbuf_pkg::REG_OFFSET2: row_offset_q[2] <= pwdata[7:0];
				lcdbuf_pkg::REG_OFFSET3: row_offset_q[3] <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			lcdbuf_pkg::REG_ROWS:    prdata = {29'd0, rows_in_use_q};
			lcdbuf_pkg::REG_COLS:    prdata = {27'd0, cols_in_use_q};
			lcdbuf_pkg::REG_OFFSET0: prdata = {24'd0, row_offset_q[0]};
			lcdbuf_pkg::REG_OFFSET1: prdata = {24'd0, row_offset_q[1]};
			lcdbuf_pkg::REG_OFFSET2: prdata = {24'd0, row_offset_q[2]};
			lcdbuf_pkg::REG_OFFSET3: prdata = {24'd0, row_offset_q[3]};
			default:                 prdata = 32'd0;
		endcase
	end

	// effective sizes
	logic [5:0] cmax;
	logic [2:0] rmax;

	always_comb begin
		if ({1'b0, cols_in_use_q} > 6'(MAX_COLS)) cmax = 6'(MAX_COLS);
		else cmax = {1'b0, cols_in_use_q};
		if (rows_in_use_q > 3'(MAX_ROWS)) rmax = 3'(MAX_ROWS);
		else rmax = rows_in_use_q;
	end

	// state
	lcdbuf_pkg::state_t state_q, state_d;

	logic [7:0]        store_mem [DEPTH];
	logic [DEPTH-1:0]  cell_vld_q;
	logic [MAX_COLS-1:0] dirty_q [MAX_ROWS];
	logic [7:0]        rd_data_q;
	logic              rd_vld_q;

	logic              wr_hit_q;
	logic [ADDR_W-1:0] wr_addr_q;
	logic [ROW_IW-1:0] row_q;
	logic [COL_IW-1:0] wr_col_q;
	logic [7:0]        wr_char_q;
	logic [6:0]        off_q;
	logic [COL_CW-1:0] col_q;
	logic [CNT_W-1:0]  cnt_q;

	logic              pend_cmd_q;
	logic [6:0]        pend_addr_q;
	logic              pend_last_q;

	lcdbuf_pkg::out_word_t out_q;
	logic              out_valid_q;

	// decoded input word
	logic              in_acc;
	logic              in_hit;
	logic [ROW_IW-1:0] in_row_idx;
	logic [COL_IW-1:0] in_col_idx;
	logic [ADDR_W-1:0] in_addr;
	logic              rf_ok;
	logic [7:0]        rf_off;

	assign in_acc     = in_valid & ~in_stall;
	assign in_hit     = (in_data.row < 3'(MAX_ROWS)) && ({1'b0, in_data.col} < 6'(MAX_COLS));
	assign in_row_idx = in_data.row[ROW_IW-1:0];
	assign in_col_idx = in_data.col[COL_IW-1:0];
	assign in_addr    = in_hit ? ADDR_W'(int'(in_row_idx) * MAX_COLS + int'(in_col_idx)) : '0;
	assign rf_off     = row_offset_q[in_data.row[1:0]];
	assign rf_ok      = (in_data.row < rmax) && !rf_off[7];

	// scan position
	logic [COL_IW-1:0] scan_col;
	logic [ADDR_W-1:0] scan_addr;
	logic              scan_end;
	logic              scan_dirty;
	logic              more_dirty;
	logic              cap_hit;
	logic [MAX_COLS-1:0] row_dirty;

	assign scan_col   = col_q[COL_IW-1:0];
	assign scan_addr  = ADDR_W'(int'(row_q) * MAX_COLS + int'(scan_col));
	assign scan_end   = {{(6 - COL_CW){1'b0}}, col_q} >= cmax;
	assign row_dirty  = dirty_q[row_q];
	assign scan_dirty = row_dirty[scan_col];
	assign cap_hit    = (cnt_q == CNT_W'(lcdbuf_pkg::RESULT_CAP - 1));

	always_comb begin
		more_dirty = 1'b0;
		for (int j = 0; j < MAX_COLS; j++) begin
			if ((6'(j) > {{(6 - COL_CW){1'b0}}, col_q}) && (6'(j) < cmax) && row_dirty[j])
				more_dirty = 1'b1;
		end
	end

	logic out_free;
	assign out_free = ~out_valid_q | ~out_stall;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			lcdbuf_pkg::ST_IDLE: begin
				if (in_acc) begin
					case (in_data.mode)
						lcdbuf_pkg::MODE_WRITE:   state_d = lcdbuf_pkg::ST_WR_CMP;
						lcdbuf_pkg::MODE_CLEAR:   state_d = lcdbuf_pkg::ST_EMIT;
						lcdbuf_pkg::MODE_REFRESH: begin
							if (rf_ok) state_d = lcdbuf_pkg::ST_SCAN;
						end
						default: ;
					endcase
				end
			end
			lcdbuf_pkg::ST_WR_CMP: state_d = lcdbuf_pkg::ST_IDLE;
			lcdbuf_pkg::ST_SCAN: begin
				if (scan_end) state_d = lcdbuf_pkg::ST_IDLE;
				else if (scan_dirty) state_d = lcdbuf_pkg::ST_EMIT;
			end
			lcdbuf_pkg::ST_EMIT: begin
				if (out_free) begin
					if (pend_last_q) state_d = lcdbuf_pkg::ST_IDLE;
					else state_d = lcdbuf_pkg::ST_SCAN;
				end
			end
			default: state_d = lcdbuf_pkg::ST_IDLE;
		endcase
	end

	// control outputs
	logic              do_clear;
	logic              do_rf_start;
	logic              do_wr_start;
	logic              mem_we;
	logic              scan_take;
	logic              scan_step;
	logic              out_load;
	logic [ADDR_W-1:0] rd_addr;

	always_comb begin
		in_stall    = 1'b1;
		do_clear    = 1'b0;
		do_rf_start = 1'b0;
		do_wr_start = 1'b0;
		mem_we      = 1'b0;
		scan_take   = 1'b0;
		scan_step   = 1'b0;
		out_load    = 1'b0;
		rd_addr     = scan_addr;
		case (state_q)
			lcdbuf_pkg::ST_IDLE: begin
				in_stall    = 1'b0;
				rd_addr     = in_addr;
				do_wr_start = in_acc && (in_data.mode == lcdbuf_pkg::MODE_WRITE);
				do_clear    = in_acc && (in_data.mode == lcdbuf_pkg::MODE_CLEAR);
				do_rf_start = in_acc && (in_data.mode == lcdbuf_pkg::MODE_REFRESH) && rf_ok;
			end
			lcdbuf_pkg::ST_WR_CMP: begin
				mem_we = wr_hit_q &&
					((rd_vld_q ? rd_data_q : lcdbuf_pkg::SPACE_CHAR) != wr_char_q);
			end
			lcdbuf_pkg::ST_SCAN: begin
				scan_take = ~scan_end & scan_dirty;
				scan_step = ~scan_end & ~scan_dirty;
			end
			lcdbuf_pkg::ST_EMIT: begin
				out_load = out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= lcdbuf_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	// character store, one write and one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) store_mem[wr_addr_q] <= wr_char_q;
		rd_data_q <= store_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_vld_q <= '0;
			rd_vld_q   <= 1'b0;
			for (int r = 0; r < MAX_ROWS; r++) dirty_q[r] <= '0;
		end else begin
			rd_vld_q <= cell_vld_q[rd_addr];
			if (do_clear) begin
				cell_vld_q <= '0;
				for (int r = 0; r < MAX_ROWS; r++) dirty_q[r] <= '0;
			end else if (mem_we) begin
				cell_vld_q[wr_addr_q]  <= 1'b1;
				dirty_q[row_q][wr_col_q] <= 1'b1;
			end else if (scan_take) begin
				dirty_q[row_q][scan_col] <= 1'b0;
			end
		end
	end

	// item and walk registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			cnt_q <= '0;
		end else if (do_rf_start) begin
			col_q <= '0;
			cnt_q <= '0;
		end else if (scan_step || (out_load && !pend_last_q)) begin
			col_q <= col_q + COL_CW'(1);
		end else if (scan_take) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr_start || do_rf_start) begin
			row_q <= in_row_idx;
		end
		if (do_wr_start) begin
			wr_hit_q  <= in_hit;
			wr_addr_q <= in_addr;
			wr_col_q  <= in_col_idx;
			wr_char_q <= in_data.char_code;
		end
		if (do_rf_start) begin
			off_q <= rf_off[6:0];
		end
		if (do_clear) begin
			pend_cmd_q  <= lcdbuf_pkg::CMD_CLEAR;
			pend_addr_q <= 7'd0;
			pend_last_q <= 1'b1;
		end else if (scan_take) begin
			pend_cmd_q  <= lcdbuf_pkg::CMD_CHAR;
			pend_addr_q <= off_q + 7'(col_q);
			pend_last_q <= cap_hit | ~more_dirty;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (out_load) out_valid_q <= 1'b1;
		else if (!out_stall) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.command       <= pend_cmd_q;
			out_q.ddram_address <= pend_addr_q;
			out_q.char_out      <= (pend_cmd_q == lcdbuf_pkg::CMD_CHAR) ?
				(rd_vld_q ? rd_data_q : lcdbuf_pkg::SPACE_CHAR) : 8'd0;
			out_q.last          <= pend_last_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
`default_nettype wire

FILE: dv/testbench.sv
`timescale 1ns / 100ps
module testbench;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int ITEMS_PER_SETTING = 42;
	localparam int SETTLE_CYCLES = 48;
	localparam int CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	lcdbuf_pkg::in_word_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	lcdbuf_pkg::out_word_t out_data;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [4:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	logic [7:0] shadow_chars [lcdbuf_pkg::MAX_ROWS_DEF][lcdbuf_pkg::MAX_COLS_DEF];
	logic [lcdbuf_pkg::MAX_COLS_DEF-1:0] dirty_rows [lcdbuf_pkg::MAX_ROWS_DEF];
	logic [2:0] rows_reg;
	logic [4:0] cols_reg;
	logic [7:0] row_base [4];

	lcdbuf_pkg::in_word_t word_queue[$];
	lcdbuf_pkg::out_word_t lcd_cmds_due[$];
	int words_queued = 0;
	int words_taken = 0;
	int results_seen = 0;
	int failures = 0;
	int cycles = 0;
	int settings_done = 0;
	bit in_taken = 1'b0;
	bit no_idle = 1'b0;

	char_lcd_dirty_cell_buffer u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #2 clk = ~clk;

	function automatic void wipe_shadow();
		foreach (shadow_chars[r, c]) shadow_chars[r][c] = lcdbuf_pkg::SPACE_CHAR;
		foreach (dirty_rows[r]) dirty_rows[r] = '0;
	endfunction

	function automatic void predict_lcd_cmds(lcdbuf_pkg::in_word_t w);
		int rmax;
		int cmax;
		int hi;
		int n;
		logic [1:0] r;
		lcdbuf_pkg::out_word_t cmd;
		r = w.row[1:0];
		case (w.mode)
		lcdbuf_pkg::MODE_WRITE: begin
			if (w.row < lcdbuf_pkg::MAX_ROWS_DEF && w.col < lcdbuf_pkg::MAX_COLS_DEF
					&& shadow_chars[r][w.col] != w.char_code) begin
				shadow_chars[r][w.col] = w.char_code;
				dirty_rows[r][w.col] = 1'b1;
			end
		end
		lcdbuf_pkg::MODE_CLEAR: begin
			wipe_shadow();
			lcd_cmds_due.push_back(
				lcdbuf_pkg::out_word_t'{lcdbuf_pkg::CMD_CLEAR, 7'd0, 8'd0, 1'b1});
		end
		lcdbuf_pkg::MODE_REFRESH: begin
			rmax = rows_reg > lcdbuf_pkg::MAX_ROWS_DEF ? lcdbuf_pkg::MAX_ROWS_DEF
				: int'(rows_reg);
			cmax = cols_reg > lcdbuf_pkg::MAX_COLS_DEF ? lcdbuf_pkg::MAX_COLS_DEF
				: int'(cols_reg);
			if (w.row < rmax && !row_base[r][7]) begin
				hi = -1;
				n = 0;
				for (int c = 0; c < cmax; c++)
					if (dirty_rows[r][c] && n < lcdbuf_pkg::RESULT_CAP) begin
						hi = c;
						n++;
					end
				for (int c = 0; c <= hi; c++)
					if (dirty_rows[r][c]) begin
						dirty_rows[r][c] = 1'b0;
						cmd.command = lcdbuf_pkg::CMD_CHAR;
						cmd.ddram_address = row_base[r][6:0] + 7'(c);
						cmd.char_out = shadow_chars[r][c];
						cmd.last = (c == hi);
						lcd_cmds_due.push_back(cmd);
					end
			end
		end
		default: ;
		endcase
	endfunction

	function automatic void check_lcd_cmd(lcdbuf_pkg::out_word_t got);
		lcdbuf_pkg::out_word_t want;
		results_seen++;
		if (lcd_cmds_due.size() == 0) begin
			$error("unexpected result word %h", got);
			failures++;
		end else begin
			want = lcd_cmds_due.pop_front();
			if (got.command !== want.command) begin
				$error("command: expected %0d, got %0d", want.command, got.command);
				failures++;
			end
			if (got.ddram_address !== want.ddram_address) begin
				$error("ddram_address: expected %h, got %h", want.ddram_address,
					got.ddram_address);
				failures++;
			end
			if (got.char_out !== want.char_out) begin
				$error("char_out: expected %h, got %h", want.char_out, got.char_out);
				failures++;
			end
			if (got.last !== want.last) begin
				$error("last: expected %0d, got %0d", want.last, got.last);
				failures++;
			end
		end
	endfunction

	always @(posedge clk) begin
		cycles++;
		in_taken = 1'b0;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				predict_lcd_cmds(in_data);
				words_taken++;
				in_taken = 1'b1;
			end
			if (out_valid && !out_stall)
				check_lcd_cmd(out_data);
		end
	end

	always @(negedge clk) begin : feed
		logic nv;
		lcdbuf_pkg::in_word_t nd;
		nv = in_valid && !in_taken;
		nd = in_data;
		if (!nv && arst_n && word_queue.size() > 0
				&& (no_idle || $urandom_range(99) >= 19)) begin
			nd = word_queue.pop_front();
			nv = 1'b1;
		end
		in_valid <= nv;
		in_data <= nd;
	end

	always @(negedge clk) begin
		out_stall <= arst_n && !no_idle && $urandom_range(99) < 19;
	end

	initial begin
		while (cycles < CYCLE_LIMIT) @(posedge clk);
		$display("run stopped at the cycle limit");
		$display("Verification failed");
		$finish;
	end

	task automatic queue_word(logic [1:0] mode, logic [2:0] row, logic [4:0] col,
			logic [7:0] ch);
		word_queue.push_back(lcdbuf_pkg::in_word_t'{mode, row, col, ch});
		words_queued++;
	endtask

	function automatic lcdbuf_pkg::in_word_t random_word();
		lcdbuf_pkg::in_word_t w;
		int pick;
		pick = $urandom_range(99);
		w.row = 3'($urandom_range(3));
		w.col = 5'($urandom_range(lcdbuf_pkg::MAX_COLS_DEF - 1));
		case ($urandom_range(3))
		0: w.char_code = lcdbuf_pkg::SPACE_CHAR;
		1: w.char_code = 8'h41 + 8'($urandom_range(1));
		default: w.char_code = 8'($urandom_range(255));
		endcase
		if (pick < 60) begin
			w.mode = lcdbuf_pkg::MODE_WRITE;
		end else if (pick < 66) begin
			w.mode = lcdbuf_pkg::MODE_WRITE;
			w.row = 3'($urandom_range(7));
			w.col = 5'($urandom_range(31));
		end else if (pick < 93) begin
			w.mode = lcdbuf_pkg::MODE_REFRESH;
			w.col = 5'($urandom_range(31));
			if (pick >= 88)
				w.row = 3'($urandom_range(7));
		end else if (pick < 97) begin
			w.mode = lcdbuf_pkg::MODE_CLEAR;
		end else begin
			w.mode = MODE_UNUSED;
			w.row = 3'($urandom_range(7));
			w.col = 5'($urandom_range(31));
		end
		return w;
	endfunction

	task automatic wait_idle();
		do @(negedge clk);
		while (words_taken != words_queued || lcd_cmds_due.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [7:0] val);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= {24'd0, val};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk);
		while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
		lcdbuf_pkg::REG_ROWS: rows_reg = val[2:0];
		lcdbuf_pkg::REG_COLS: cols_reg = val[4:0];
		lcdbuf_pkg::REG_OFFSET0: row_base[0] = val;
		lcdbuf_pkg::REG_OFFSET1: row_base[1] = val;
		lcdbuf_pkg::REG_OFFSET2: row_base[2] = val;
		lcdbuf_pkg::REG_OFFSET3: row_base[3] = val;
		default: ;
		endcase
	endtask

	task automatic apply_and_run(logic [2:0] rows, logic [4:0] cols, logic [7:0] o0,
			logic [7:0] o1, logic [7:0] o2, logic [7:0] o3);
		lcdbuf_pkg::in_word_t w;
		write_reg(lcdbuf_pkg::REG_ROWS, 8'(rows));
		write_reg(lcdbuf_pkg::REG_COLS, 8'(cols));
		write_reg(lcdbuf_pkg::REG_OFFSET0, o0);
		write_reg(lcdbuf_pkg::REG_OFFSET1, o1);
		write_reg(lcdbuf_pkg::REG_OFFSET2, o2);
		write_reg(lcdbuf_pkg::REG_OFFSET3, o3);
		settings_done++;
		for (int i = 0; i < ITEMS_PER_SETTING; i++) begin
			w = random_word();
			queue_word(w.mode, w.row, w.col, w.char_code);
		end
		wait_idle();
	endtask

	function automatic logic [7:0] random_offset();
		return 8'($urandom_range(128)) - 8'd1;
	endfunction

	initial begin
		wipe_shadow();
		rows_reg = lcdbuf_pkg::ROWS_RST;
		cols_reg = lcdbuf_pkg::COLS_RST;
		row_base[0] = lcdbuf_pkg::OFFSET0_RST;
		row_base[1] = lcdbuf_pkg::OFFSET1_RST;
		row_base[2] = lcdbuf_pkg::OFFSET2_RST;
		row_base[3] = lcdbuf_pkg::OFFSET3_RST;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		queue_word(lcdbuf_pkg::MODE_REFRESH, 3'd0, 5'd0, 8'h00);
		queue_word(lcdbuf_pkg::MODE_WRITE, 3'd0, 5'd0, 8'h41);
		queue_word(lcdbuf_pkg::MODE_WRITE, 3'd0, 5'd19, 8'hFF);
		queue_word(lcdbuf_pkg::MODE_WRITE, 3'd0, 5'd5, lcdbuf_pkg::SPACE_CHAR);
		queue_word(lcdbuf_pkg::MODE_WRITE, 3'd3, 5'd19, 8'h00);
		queue_word(lcdbuf_pkg::MODE_WRITE, 3'd4, 5'd0, 8'h78);
		queue_word(lcdbuf_pkg::MODE_WRITE, 3'd7, 5'd31, 8'hFF);
		queue_word(lcdbuf_pkg::MODE_WRITE, 3'd0, 5'd20, 8'h71);
		queue_word(lcdbuf_pkg::MODE_WRITE, 3'd1, 5'd31, 8'h55);
		queue_word(lcdbuf_pkg::MODE_WRITE, 3'd0, 5'd0, 8'h41);
		queue_word(MODE_UNUSED, 3'd7, 5'd31, 8'hFF);
		queue_word(lcdbuf_pkg::MODE_REFRESH, 3'd0, 5'd0, 8'h00);
		queue_word(lcdbuf_pkg::MODE_REFRESH, 3'd0, 5'd0, 8'h00);
		queue_word(lcdbuf_pkg::MODE_REFRESH, 3'd3, 5'd0, 8'h00);
		queue_word(lcdbuf_pkg::MODE_REFRESH, 3'd5, 5'd0, 8'h00);
		queue_word(lcdbuf_pkg::MODE_WRITE, 3'd1, 5'd10, 8'h42);
		queue_word(lcdbuf_pkg::MODE_CLEAR, 3'd0, 5'd0, 8'h00);
		queue_word(lcdbuf_pkg::MODE_REFRESH, 3'd1, 5'd0, 8'h00);
		queue_word(lcdbuf_pkg::MODE_WRITE, 3'd2, 5'd0, 8'h80);
		queue_word(lcdbuf_pkg::MODE_REFRESH, 3'd2, 5'd31, 8'hFF);
		wait_idle();

		apply_and_run(3'd4, 5'd20, 8'h00, 8'h40, 8'h14, 8'h54);
		apply_and_run(3'd1, 5'd1, 8'hFF, 8'h7F, 8'h00, 8'hFF);
		no_idle = 1'b1;
		apply_and_run(3'd7, 5'd31, 8'h7F, 8'h6C, 8'hFF, 8'h01);
		no_idle = 1'b0;
		apply_and_run(3'd0, 5'd0, 8'h00, 8'h40, 8'h14, 8'h54);
		apply_and_run(3'd3, 5'd17, random_offset(), random_offset(), random_offset(),
			random_offset());
		apply_and_run(3'd2, 5'd5, random_offset(), random_offset(), random_offset(),
			random_offset());
		apply_and_run(3'd4, 5'd20, 8'h00, 8'h40, 8'h14, 8'h54);

		$display("%0d words sent over %0d register settings, %0d result words checked",
			words_taken, settings_done, results_seen);
		if (failures == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
